### hdl/matrix4_inverse_adjugate_core_macros.svh
// assertion macros for the 4x4 inverse core
// used by the top level only, expects clk_i and rst_ni in scope
`ifndef MATRIX4_INVERSE_ADJUGATE_CORE_MACROS_SVH
`define MATRIX4_INVERSE_ADJUGATE_CORE_MACROS_SVH

// generic clocked property, off during reset
`define M4I_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication form
`define M4I_ASSERT_IMP(lbl, ante, cons, msg) \
  `M4I_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

### hdl/m4inv_pkg.sv
// shared types and constants for the 4x4 adjugate inverse core
// no dependencies
package m4inv_pkg;

  localparam int ElemW = 32;   // element width
  localparam int CofW  = 100;  // 3x3 cofactor width
  localparam int DetW  = 136;  // determinant and multiplier accumulator width
  localparam int RemW  = 170;  // divider remainder width

  localparam logic [33:0] SatPos = 34'h0_7FFF_FFFF;
  localparam logic [33:0] SatNeg = 34'h0_8000_0000;

  typedef struct packed {
    logic [3:0]              elem_index;
    logic signed [ElemW-1:0] elem_value;
    logic                    elem_last;
  } in_t;

  typedef struct packed {
    logic [3:0]              out_index;
    logic signed [ElemW-1:0] out_value;
    logic                    singular;
    logic                    out_last;
  } out_t;

  // minor column chosen for minor row m in term t of the 3x3 expansion
  function automatic logic [1:0] perm_col(logic [2:0] t, logic [1:0] m);
    logic [5:0] p;
    unique case (t)
      3'd0:    p = {2'd2, 2'd1, 2'd0};
      3'd1:    p = {2'd0, 2'd2, 2'd1};
      3'd2:    p = {2'd1, 2'd0, 2'd2};
      3'd3:    p = {2'd1, 2'd2, 2'd0};
      3'd4:    p = {2'd0, 2'd1, 2'd2};
      3'd5:    p = {2'd2, 2'd0, 2'd1};
      default: p = '0;
    endcase
    unique case (m)
      2'd0:    return p[1:0];
      2'd1:    return p[3:2];
      default: return p[5:4];
    endcase
  endfunction

  // odd permutations carry a minus sign
  function automatic logic perm_neg(logic [2:0] t);
    return (t >= 3'd3);
  endfunction

  // map a minor index to the full index, skipping the removed one
  function automatic logic [1:0] skip_idx(logic [1:0] m, logic [1:0] x);
    return (m >= x) ? m + 2'd1 : m;
  endfunction

endpackage

### hdl/m4inv_mul.sv
// bit-serial signed multiplier, one multiplier bit per cycle
// depends on m4inv_pkg
module m4inv_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [m4inv_pkg::DetW-1:0]   a_i,
  input  logic [m4inv_pkg::ElemW-1:0]  b_i,
  output logic                         done_o,
  output logic [m4inv_pkg::DetW-1:0]   prod_o
);
  import m4inv_pkg::*;

  localparam int CntW = $clog2(ElemW);

  logic [DetW-1:0]  mcand_q, acc_q;
  logic [ElemW-1:0] mplier_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic             last_bit;

  assign last_bit = (cnt_q == CntW'(ElemW - 1));

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (last_bit) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // shift-add datapath, sign bit of the multiplier subtracts
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q  <= a_i;
      mplier_q <= b_i;
      acc_q    <= '0;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_q <= last_bit ? acc_q - mcand_q : acc_q + mcand_q;
      end
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

### hdl/m4inv_div.sv
// bit-serial restoring divider with Q16.16 saturation, one quotient bit per cycle
// depends on m4inv_pkg
module m4inv_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [m4inv_pkg::RemW-1:0]   num_i,
  input  logic [m4inv_pkg::DetW-1:0]   den_i,
  input  logic                         neg_i,
  output logic                         done_o,
  output logic [m4inv_pkg::ElemW-1:0]  quot_o
);
  import m4inv_pkg::*;

  logic [RemW-1:0] rem_q, dsr_q;
  logic [33:0]     q_q;
  logic [5:0]      cnt_q;
  logic            neg_q, busy_q, done_q;
  logic            ge;

  assign ge = (rem_q >= dsr_q);

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd33) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient bits 33 down to 0, bit 33 only flags overflow
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsr_q <= RemW'(den_i) << 33;
      q_q   <= '0;
      neg_q <= neg_i;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dsr_q;
      end
      q_q   <= {q_q[32:0], ge};
      dsr_q <= dsr_q >> 1;
    end
  end

  // saturate and apply sign
  always_comb begin
    if (neg_q) begin
      quot_o = (q_q > SatNeg) ? SatNeg[31:0] : (~q_q[31:0] + 32'd1);
    end else begin
      quot_o = (q_q > SatPos) ? SatPos[31:0] : q_q[31:0];
    end
  end

  assign done_o = done_q;

endmodule

### hdl/matrix4_inverse_adjugate_core.sv
// 4x4 inverse by adjugate: loads update the stored matrix, and the load flagged last starts the work;
// each cofactor is 6 terms of two bit-serial multiplies, the determinant 4 more,
// and each result one bit-serial divide unless singular; one multiplier is shared by all of these.
// one load per cycle while idle; no loads are taken until the last result has been issued.
// reset (rst_ni low, async) clears control and sets the threshold to its default;
// the matrix store holds no reset value.
`include "matrix4_inverse_adjugate_core_macros.svh"
module matrix4_inverse_adjugate_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  m4inv_pkg::in_t     in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output m4inv_pkg::out_t    out_data_o,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i
);
  import m4inv_pkg::*;

  localparam int                ThrShift = 4 * FRAC_BITS - 32;
  localparam int                NumShift = 2 * FRAC_BITS;
  localparam logic [ElemW-1:0]  OneQ     = ElemW'(1) << FRAC_BITS;
  localparam logic [31:0]       ThrReset = 32'd42950;

  typedef enum logic [3:0] {
    S_IDLE, S_CFETCH, S_M1S, S_M1W, S_M2S, S_M2W, S_CACC, S_CWR,
    S_DFETCH, S_DMS, S_DMW, S_CHK, S_ORD, S_ODS, S_ODW, S_EMIT
  } state_e;

  state_e state_q;

  logic [31:0]             thr_q;
  logic [3:0]              k_q;
  logic [2:0]              term_q;
  logic [1:0]              fcnt_q, j_q;
  logic signed [ElemW-1:0] e_q [3];
  logic [DetW-1:0]         cacc_q, det_q, adet_q;
  logic                    sing_q;
  logic [ElemW-1:0]        val_q;
  logic                    out_valid_q;
  out_t                    out_q;

  logic signed [ElemW-1:0] mat_mem [16];
  logic signed [ElemW-1:0] mat_rd_q;
  logic [3:0]              mat_raddr;
  logic signed [CofW-1:0]  cof_mem [16];
  logic signed [CofW-1:0]  cof_rd_q;
  logic [3:0]              cof_raddr;

  logic                    in_acc;
  logic [1:0]              row_r, col_c, mrow, mcol;
  logic                    mul_start, mul_done;
  logic [DetW-1:0]         mul_a, mul_prod;
  logic [ElemW-1:0]        mul_b;
  logic                    div_start, div_done;
  logic [ElemW-1:0]        div_quot;
  logic [CofW-1:0]         cof_mag;
  logic [DetW-1:0]         det_abs, thr_lim;
  logic                    emit_ok;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // element address of the current 3x3 minor entry
  assign row_r = k_q[3:2];
  assign col_c = k_q[1:0];
  assign mrow  = skip_idx(fcnt_q, row_r);
  assign mcol  = skip_idx(perm_col(term_q, fcnt_q), col_c);

  always_comb begin
    unique case (state_q)
      S_CFETCH: mat_raddr = {mrow, mcol};
      S_DFETCH: mat_raddr = {2'd0, j_q};
      default:  mat_raddr = '0;
    endcase
    unique case (state_q)
      S_DFETCH: cof_raddr = {2'd0, j_q};
      S_ORD:    cof_raddr = {k_q[1:0], k_q[3:2]};
      default:  cof_raddr = '0;
    endcase
  end

  // matrix and cofactor stores
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mat_mem[in_data_i.elem_index] <= in_data_i.elem_value;
    end
    mat_rd_q <= mat_mem[mat_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_CWR) begin
      cof_mem[k_q] <= (k_q[2] ^ k_q[0]) ? CofW'(-cacc_q) : CofW'(cacc_q);
    end
    cof_rd_q <= cof_mem[cof_raddr];
  end

  // shared multiplier operand select
  assign mul_start = (state_q == S_M1S) || (state_q == S_M2S) || (state_q == S_DMS);
  always_comb begin
    unique case (state_q)
      S_M1S: begin
        mul_a = DetW'(e_q[0]);
        mul_b = e_q[1];
      end
      S_M2S: begin
        mul_a = mul_prod;
        mul_b = e_q[2];
      end
      default: begin
        mul_a = DetW'(cof_rd_q);
        mul_b = mat_rd_q;
      end
    endcase
  end

  m4inv_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // divider operands
  assign cof_mag   = cof_rd_q[CofW-1] ? CofW'(-cof_rd_q) : CofW'(cof_rd_q);
  assign div_start = (state_q == S_ODS);

  m4inv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (RemW'(cof_mag) << NumShift),
    .den_i   (adet_q),
    .neg_i   (cof_rd_q[CofW-1] ^ det_q[DetW-1]),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // singularity test values
  assign det_abs = det_q[DetW-1] ? -det_q : det_q;
  assign thr_lim = DetW'(thr_q) << ThrShift;
  assign emit_ok = !out_valid_q || out_ready_i;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      thr_q       <= ThrReset;
      k_q         <= '0;
      term_q      <= '0;
      fcnt_q      <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      // drop the result once taken, unless a new one replaces it this cycle
      if (out_valid_q && out_ready_i && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && in_data_i.elem_last) begin
            k_q     <= '0;
            term_q  <= '0;
            fcnt_q  <= '0;
            cacc_q  <= '0;
            state_q <= S_CFETCH;
          end
        end
        S_CFETCH: begin
          if (fcnt_q != 2'd0) begin
            e_q[fcnt_q - 2'd1] <= mat_rd_q;
          end
          fcnt_q <= fcnt_q + 2'd1;
          if (fcnt_q == 2'd3) begin
            state_q <= S_M1S;
          end
        end
        S_M1S: state_q <= S_M1W;
        S_M1W: if (mul_done) state_q <= S_M2S;
        S_M2S: state_q <= S_M2W;
        S_M2W: if (mul_done) state_q <= S_CACC;
        S_CACC: begin
          cacc_q <= perm_neg(term_q) ? cacc_q - mul_prod : cacc_q + mul_prod;
          fcnt_q <= '0;
          if (term_q == 3'd5) begin
            term_q  <= '0;
            state_q <= S_CWR;
          end else begin
            term_q  <= term_q + 3'd1;
            state_q <= S_CFETCH;
          end
        end
        S_CWR: begin
          cacc_q <= '0;
          k_q    <= k_q + 4'd1;
          if (k_q == 4'd15) begin
            j_q     <= '0;
            det_q   <= '0;
            state_q <= S_DFETCH;
          end else begin
            state_q <= S_CFETCH;
          end
        end
        S_DFETCH: state_q <= S_DMS;
        S_DMS:    state_q <= S_DMW;
        S_DMW: begin
          if (mul_done) begin
            det_q <= det_q + mul_prod;
            j_q   <= j_q + 2'd1;
            state_q <= (j_q == 2'd3) ? S_CHK : S_DFETCH;
          end
        end
        S_CHK: begin
          adet_q  <= det_abs;
          sing_q  <= (det_q == '0) || (det_abs < thr_lim);
          k_q     <= '0;
          state_q <= S_ORD;
        end
        S_ORD: begin
          if (sing_q) begin
            val_q   <= (k_q[3:2] == k_q[1:0]) ? OneQ : '0;
            state_q <= S_EMIT;
          end else begin
            state_q <= S_ODS;
          end
        end
        S_ODS: state_q <= S_ODW;
        S_ODW: begin
          if (div_done) begin
            val_q   <= div_quot;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            out_valid_q        <= 1'b1;
            out_q.out_index    <= k_q;
            out_q.out_value    <= val_q;
            out_q.singular     <= sing_q;
            out_q.out_last     <= (k_q == 4'd15);
            k_q                <= k_q + 4'd1;
            state_q            <= (k_q == 4'd15) ? S_IDLE : S_ORD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `M4I_ASSERT_IMP(a_mul_done_state, mul_done,
    (state_q == S_M1W) || (state_q == S_M2W) || (state_q == S_DMW),
    "multiplier finished outside a wait state")
  `M4I_ASSERT_IMP(a_div_done_state, div_done, state_q == S_ODW,
    "divider finished outside its wait state")
  `M4I_ASSERT_IMP(a_singular_identity, out_valid_o && out_data_o.singular,
    out_data_o.out_value == ((out_data_o.out_index[3:2] == out_data_o.out_index[1:0])
    ? OneQ : '0), "singular result is not the identity")

endmodule

### tb/sv/matrix4_inverse_adjugate_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the 4x4 adjugate inverse core
// depends on m4inv_pkg and matrix4_inverse_adjugate_core
module matrix4_inverse_adjugate_core_tb;
  import m4inv_pkg::*;

  localparam int FRAC = 16;

  typedef logic signed [255:0] wide_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_we;
  logic [31:0] cfg_wdata;

  // pending loads, expected inverse elements, shadow state
  in_t load_q[$];
  out_t inv_q[$];
  logic signed [31:0] mat_shadow[16];
  logic [31:0] thr_shadow;
  bit no_idle;
  int err_cnt;

  matrix4_inverse_adjugate_core #(.FRAC_BITS(FRAC)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic wide_t elem_at(int r, int c);
    wide_t e;
    e = mat_shadow[r*4+c];
    return e;
  endfunction

  // signed cofactor of row r, column c
  function automatic wide_t cofactor_of(int r, int c);
    wide_t v[9];
    wide_t d;
    int k;
    k = 0;
    for (int i = 0; i < 4; i++) begin
      if (i == r) continue;
      for (int j = 0; j < 4; j++) begin
        if (j == c) continue;
        v[k] = elem_at(i, j);
        k++;
      end
    end
    d = v[0] * (v[4]*v[8] - v[5]*v[7]) - v[1] * (v[3]*v[8] - v[5]*v[6])
        + v[2] * (v[3]*v[7] - v[4]*v[6]);
    return ((r + c) % 2 == 1) ? -d : d;
  endfunction

  // store a load; on the last one predict the 16 inverse elements
  function automatic void predict_inverse(in_t it);
    wide_t det, cof;
    logic [255:0] adet, num, quo, lim;
    logic [31:0] v;
    bit sing, neg;
    out_t o;
    mat_shadow[it.elem_index] = it.elem_value;
    if (!it.elem_last) return;
    det = '0;
    for (int j = 0; j < 4; j++) det = det + elem_at(0, j) * cofactor_of(0, j);
    adet = (det < 0) ? -det : det;
    lim = {224'd0, thr_shadow} << (4*FRAC - 32);
    sing = (det == 0) || (adet < lim);
    for (int k = 0; k < 16; k++) begin
      if (sing) begin
        v = (k/4 == k%4) ? (32'd1 << FRAC) : 32'd0;
      end else begin
        cof = cofactor_of(k%4, k/4);
        neg = (cof < 0) != (det < 0);
        num = ((cof < 0) ? -cof : cof) << (2*FRAC);
        quo = num / adet;
        if (neg) v = (quo > 256'h8000_0000) ? 32'h8000_0000 : -quo[31:0];
        else v = (quo > 256'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
      end
      o.out_index = k[3:0];
      o.out_value = v;
      o.singular = sing;
      o.out_last = (k == 15);
      inv_q.push_back(o);
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    err_cnt++;
  endtask

  // driver: load transactions from the pending queue
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && in_ready) predict_inverse(in_data);
      if (!in_valid || in_ready) begin
        if (load_q.size() > 0 && (no_idle || $urandom_range(99) >= 12)) begin
          in_data <= load_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result transaction against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (inv_q.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_data), 64'd0);
        end else begin
          out_t w;
          w = inv_q.pop_front();
          if (out_data.out_index !== w.out_index)
            report_mismatch("out_index", 64'(out_data.out_index), 64'(w.out_index));
          if (out_data.out_value !== w.out_value)
            report_mismatch("out_value", 64'(unsigned'(out_data.out_value)),
                            64'(unsigned'(w.out_value)));
          if (out_data.singular !== w.singular)
            report_mismatch("singular", 64'(out_data.singular), 64'(w.singular));
          if (out_data.out_last !== w.out_last)
            report_mismatch("out_last", 64'(out_data.out_last), 64'(w.out_last));
        end
      end
      out_ready <= no_idle || ($urandom_range(99) >= 12);
    end
  end

  function automatic void push_load(int idx, logic [31:0] val, bit last);
    in_t it;
    it.elem_index = idx[3:0];
    it.elem_value = val;
    it.elem_last = last;
    load_q.push_back(it);
  endfunction

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(16)) - 8) << FRAC;
      default: return 32'($signed($urandom_range(1 << 20)) - (1 << 19)) << 2;
    endcase
  endfunction

  // whole matrix in random order, or a partial update; last flag on the final load
  function automatic int push_random_matrix();
    int order[16];
    int n;
    for (int i = 0; i < 16; i++) order[i] = i;
    order.shuffle();
    n = ($urandom_range(3) == 0) ? $urandom_range(1, 6) : 16;
    for (int i = 0; i < n; i++) begin
      // occasionally copy the row 0 element of the same column, toward a singular matrix
      if ($urandom_range(9) == 0 && order[i] >= 4)
        push_load(order[i], mat_shadow[order[i] % 4], i == n - 1);
      else
        push_load(order[i], rand_elem(), i == n - 1);
    end
    return n;
  endfunction

  // sampled at the falling edge so the driver and monitor have settled
  task automatic wait_idle();
    while (load_q.size() > 0 || in_valid || inv_q.size() > 0) @(negedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    thr_shadow = val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // stimulus
  initial begin
    int n_items;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    thr_shadow = 32'd42950;
    no_idle = 1'b0;
    err_cnt = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity, zero determinant, tiny pivot both signs, extreme element values
    for (int i = 0; i < 16; i++) push_load(i, (i/4 == i%4) ? 32'h0001_0000 : 32'd0, i == 15);
    push_load(0, 32'd0, 1'b1);
    push_load(0, 32'd1, 1'b1);
    push_load(0, 32'hFFFF_FFFF, 1'b1);
    push_load(0, 32'h7FFF_FFFF, 1'b1);
    push_load(0, 32'h8000_0000, 1'b1);
    wait_idle();

    // threshold zero: a zero determinant still counts as singular
    write_threshold(32'd0);
    push_load(0, 32'd0, 1'b1);
    push_load(0, 32'd1, 1'b1);
    wait_idle();

    // maximum threshold: a unit determinant still lies just above it
    write_threshold(32'hFFFF_FFFF);
    push_load(0, 32'h0001_0000, 1'b1);
    wait_idle();

    // random phases, each with its own threshold
    n_items = 0;
    for (int ph = 0; n_items < 135; ph++) begin
      case (ph % 4)
        0: write_threshold(32'd42950);
        1: write_threshold($urandom_range(1 << 20));
        2: write_threshold($urandom());
        default: write_threshold(32'd0);
      endcase
      no_idle = (ph == 2);
      for (int m = 0; m < 2; m++) begin
        // stray loads with no last flag in between
        if ($urandom_range(2) == 0) begin
          push_load($urandom_range(15), rand_elem(), 1'b0);
          n_items++;
        end
        n_items += push_random_matrix();
      end
      wait_idle();
    end
    no_idle = 1'b0;

    wait_idle();
    repeat (100) @(posedge clk_i);
    if (err_cnt == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #30000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/m4inv_pkg.sv
hdl/m4inv_mul.sv
hdl/m4inv_div.sv
hdl/matrix4_inverse_adjugate_core.sv
tb/sv/matrix4_inverse_adjugate_core_tb.sv
